// ===== design/srms_pkg.sv =====
// shared types and constants for the stable record merge sort block
// no dependencies
package srms_pkg;

  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SALARY_W = 32;
  localparam int unsigned NAME_W   = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0]    key;
    logic signed [SALARY_W-1:0] salary;
    logic [NAME_W-1:0]          name_ref;
  } rec_t;

  // what one cell shows its neighbors
  typedef struct packed {
    rec_t rec;
    logic valid;
    logic gt;
  } link_t;

  // control broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } ctl_t;

endpackage

// ===== design/stable_record_merge_sort_top.sv =====
// stable record sorter: load, sort by key, emit in order
// depends on srms_pkg and srms_chain
//
// input channel: in_valid_i/in_ready_o carry one record per item with
// key_i, salary_i, name_ref_i and last_item_i. records are kept in a row of
// cells ordered by signed key as they arrive; equal keys stay in arrival
// order. records past the capacity of 64 are dropped and the set is
// flagged.
// an item with last_item_i closes the set; the first sorted item shows on
// out_valid_o in the next cycle and one item leaves per cycle while
// out_ready_i is high. end_of_run_o marks the final item, overflowed_o is
// set on every item of a set that dropped records.
// in_ready_o is low while a set drains; a stalled receiver holds the head
// item and the cell row in place.
// reset empties the cell row and clears the count and overflow flag; the
// block comes out of reset ready to load.
module stable_record_merge_sort_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [srms_pkg::KEY_W-1:0]    key_i,
  input  logic signed [srms_pkg::SALARY_W-1:0] salary_i,
  input  logic [srms_pkg::NAME_W-1:0]          name_ref_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [srms_pkg::KEY_W-1:0]    out_key_o,
  output logic signed [srms_pkg::SALARY_W-1:0] out_salary_o,
  output logic [srms_pkg::NAME_W-1:0]          out_name_ref_o,
  output logic                               end_of_run_o,
  output logic                               overflowed_o
);
  import srms_pkg::*;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             in_acc, out_acc, full;
  ctl_t             ctl;
  rec_t             new_rec;
  link_t            head;
  logic             second_valid;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == CNT_W'(MAX_RECORDS));

  assign new_rec.key      = key_i;
  assign new_rec.salary   = salary_i;
  assign new_rec.name_ref = name_ref_i;

  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = out_acc;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_item_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc && !second_valid) begin
          state_d = ST_LOAD;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  srms_chain u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .new_rec_i      (new_rec),
    .head_o         (head),
    .second_valid_o (second_valid)
  );

  assign out_key_o      = head.rec.key;
  assign out_salary_o   = head.rec.salary;
  assign out_name_ref_o = head.rec.name_ref;
  assign end_of_run_o   = !second_valid;
  assign overflowed_o   = ovf_q;

endmodule

// ===== design/srms_cell.sv =====
// one sorting cell: holds one record, inserts in key order, shifts toward the head
// depends on srms_pkg
module srms_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srms_pkg::ctl_t  ctl_i,
  input  srms_pkg::rec_t  new_rec_i,
  input  srms_pkg::link_t left_i,
  input  srms_pkg::link_t right_i,
  output srms_pkg::link_t self_o
);
  import srms_pkg::*;

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;
  logic gt;

  // strictly greater keeps equal keys in arrival order
  assign gt = valid_q && (rec_q.key > new_rec_i.key);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctl_i.shift) begin
      rec_d   = right_i.rec;
      valid_d = right_i.valid;
    end else if (ctl_i.insert) begin
      if (left_i.gt) begin
        rec_d = left_i.rec;
      end else if (gt || (!valid_q && left_i.valid)) begin
        rec_d = new_rec_i;
      end
      valid_d = valid_q | left_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign self_o.rec   = rec_q;
  assign self_o.valid = valid_q;
  assign self_o.gt    = gt;

endmodule

// ===== design/srms_chain.sv =====
// row of sorting cells joined to their neighbors
// depends on srms_pkg and srms_cell
module srms_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srms_pkg::ctl_t  ctl_i,
  input  srms_pkg::rec_t  new_rec_i,
  output srms_pkg::link_t head_o,
  output logic            second_valid_o
);
  import srms_pkg::*;

  link_t cells [MAX_RECORDS];
  link_t lefts [MAX_RECORDS];
  link_t rights[MAX_RECORDS];

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{rec: new_rec_i, valid: 1'b1, gt: 1'b0};
    end else begin : g_mid_left
      assign lefts[i] = cells[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_last
      assign rights[i] = '{rec: new_rec_i, valid: 1'b0, gt: 1'b0};
    end else begin : g_mid_right
      assign rights[i] = cells[i+1];
    end

    srms_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .new_rec_i (new_rec_i),
      .left_i    (lefts[i]),
      .right_i   (rights[i]),
      .self_o    (cells[i])
    );
  end

  assign head_o         = cells[0];
  assign second_valid_o = cells[1].valid;

endmodule

// ===== bench/tb.sv =====
// testbench for stable_record_merge_sort_top: sends record sets, predicts the stable key order
// and checks every sorted item field by field; depends on srms_pkg and the design files
module tb;
  import srms_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    logic signed [KEY_W-1:0]    key;
    logic signed [SALARY_W-1:0] salary;
    logic [NAME_W-1:0]          name_ref;
    logic                       end_run;
    logic                       dropped;
  } sorted_rec_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [KEY_W-1:0]    key_i;
  logic signed [SALARY_W-1:0] salary_i;
  logic [NAME_W-1:0]          name_ref_i;
  logic                       last_item_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [KEY_W-1:0]    out_key_o;
  logic signed [SALARY_W-1:0] out_salary_o;
  logic [NAME_W-1:0]          out_name_ref_o;
  logic                       end_of_run_o;
  logic                       overflowed_o;

  sorted_rec_t sorted_q[$];
  sorted_rec_t loaded_rec[MAX_RECORDS];
  sorted_rec_t exp_rec;
  int          loaded_n;
  logic        set_dropped;

  int error_cnt;
  int send_idle_pct;
  int stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  stable_record_merge_sort_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_i          (key_i),
    .salary_i       (salary_i),
    .name_ref_i     (name_ref_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_key_o      (out_key_o),
    .out_salary_o   (out_salary_o),
    .out_name_ref_o (out_name_ref_o),
    .end_of_run_o   (end_of_run_o),
    .overflowed_o   (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_key();
    int sel;
    int near;
    sel = $urandom_range(9);
    near = $urandom_range(6);
    if (sel < 4) return $urandom;
    if (sel < 8) return 32'(near - 3);
    return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [31:0] pick_salary();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return 32'h8000_0000;
    if (sel == 1) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic check_field(string what, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, exp, got);
      error_cnt++;
    end
  endtask

  // sends one item and updates the expected sort order once it is accepted
  task automatic send_record(logic [31:0] key, logic [31:0] salary, logic [15:0] name,
                             logic last);
    sorted_rec_t r;
    int pos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_i       <= key;
    salary_i    <= salary;
    name_ref_i  <= name;
    last_item_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (loaded_n < MAX_RECORDS) begin
      pos = loaded_n;
      while (pos > 0 && $signed(loaded_rec[pos-1].key) > $signed(key)) begin
        loaded_rec[pos] = loaded_rec[pos-1];
        pos--;
      end
      r.key      = key;
      r.salary   = salary;
      r.name_ref = name;
      r.end_run  = 1'b0;
      r.dropped  = 1'b0;
      loaded_rec[pos] = r;
      loaded_n++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < loaded_n; i++) begin
        r = loaded_rec[i];
        r.end_run = (i == loaded_n - 1);
        r.dropped = set_dropped;
        sorted_q.push_back(r);
      end
      loaded_n    = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++)
      send_record(pick_key(), pick_salary(), 16'($urandom_range(65535)), i == n - 1);
  endtask

  task automatic wait_sets_out();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_record(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0);
    send_record(32'h7fff_ffff, 32'h8000_0000, 16'h0000, 1'b0);
    send_record(32'h0000_0000, 32'h0000_0000, 16'h1234, 1'b0);
    send_record(32'hffff_ffff, 32'hffff_ffff, 16'h00ff, 1'b0);
    send_record(32'h0000_0001, 32'h0000_0001, 16'hff00, 1'b1);
    // set of one record
    send_record(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 1'b1);
  endtask

  task automatic test_equal_keys();
    send_record(32'd5, 32'd100, 16'd1, 1'b0);
    send_record(32'd5, 32'd200, 16'd2, 1'b0);
    send_record(-32'sd2, 32'd300, 16'd3, 1'b0);
    send_record(32'd5, 32'd400, 16'd4, 1'b0);
    send_record(-32'sd2, 32'd500, 16'd5, 1'b0);
    send_record(32'd5, 32'd600, 16'd6, 1'b1);
    send_record(32'h8000_0000, 32'd7, 16'd7, 1'b0);
    send_record(32'h8000_0000, 32'd8, 16'd8, 1'b1);
  endtask

  task automatic test_set_capacity();
    stall_pct = 10;
    // last item arrives when the set is already full and gets dropped
    send_random_set(MAX_RECORDS + 2);
  endtask

  task automatic test_receiver_hold();
    wait_sets_out();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req <= hold_req + 1;
    send_random_set(12);
    send_random_set(12);
  endtask

  task automatic test_random_sets(int idle_pct, int stall, int items);
    int sent;
    int n;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(70, 40) : $urandom_range(12, 1);
      if (n > items - sent) n = items - sent;
      send_random_set(n);
      sent += n;
    end
  endtask

  // checks sorted items and drives the receiver side
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected item key %0h salary %0h name %0h", $time, out_key_o,
                 out_salary_o, out_name_ref_o);
        error_cnt++;
      end else begin
        exp_rec = sorted_q.pop_front();
        check_field("key", exp_rec.key, out_key_o);
        check_field("salary", exp_rec.salary, out_salary_o);
        check_field("name_ref", 32'(exp_rec.name_ref), 32'(out_name_ref_o));
        check_field("end_of_run", 32'(exp_rec.end_run), 32'(end_of_run_o));
        check_field("overflowed", 32'(exp_rec.dropped), 32'(overflowed_o));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    error_cnt     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    loaded_n      = 0;
    set_dropped   = 1'b0;
    hold_req      <= 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    key_i         <= '0;
    salary_i      <= '0;
    name_ref_i    <= '0;
    last_item_i   <= 1'b0;
    out_ready_i   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_equal_keys();
    test_set_capacity();
    test_receiver_hold();
    test_random_sets(0, 0, 24);
    test_random_sets(82, 0, 24);
    test_random_sets(0, 82, 24);
    test_random_sets(10, 10, 24);

    wait_sets_out();
    repeat (2 * MAX_RECORDS + 16) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
